// ===== rtl/core/rgsd_pkg.sv =====
// rgsd_pkg: field widths, configuration register indexes and the result record
// of the regular graph shortcode decoder. No dependencies.
package rgsd_pkg;

  localparam int BYTE_W     = 8;
  localparam int VTX_W      = 6;
  localparam int SLOT_W     = 4;
  localparam int CNT_W      = 6;
  localparam int DEG_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VERTEX_DEGREE = 2'd1;

  typedef struct packed {
    logic [VTX_W-1:0]  first_vertex;
    logic [SLOT_W-1:0] first_slot;
    logic [VTX_W-1:0]  second_vertex;
    logic [SLOT_W-1:0] second_slot;
    logic              graph_done;
    logic              faulty;
  } rgsd_result_t;

endpackage

// ===== rtl/core/rgsd_if.sv =====
// rgsd_if: valid/ready channels of the shortcode decoder (code bytes, edges,
// configuration writes). Depends on rgsd_pkg.
interface rgsd_code_if;
  import rgsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              stream_end;
  modport source(output valid, code_byte, stream_end, input ready);
  modport sink(input valid, code_byte, stream_end, output ready);
endinterface

interface rgsd_edge_if;
  import rgsd_pkg::*;
  logic              valid;
  logic              ready;
  logic [VTX_W-1:0]  first_vertex;
  logic [SLOT_W-1:0] first_slot;
  logic [VTX_W-1:0]  second_vertex;
  logic [SLOT_W-1:0] second_slot;
  logic              graph_done;
  logic              faulty;
  modport source(output valid, first_vertex, first_slot, second_vertex, second_slot,
                 graph_done, faulty, input ready);
  modport sink(input valid, first_vertex, first_slot, second_vertex, second_slot,
               graph_done, faulty, output ready);
endinterface

interface rgsd_cfg_if;
  import rgsd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/regular_graph_shortcode_decoder.sv =====
// regular_graph_shortcode_decoder: decodes prefix-compressed shortcodes of
// k-regular graphs into edges. Depends on rgsd_pkg and rgsd_if.
//
// Channels: codes carries one stream byte (code_byte) or a stream end marker
// per transfer; edges carries one edge (v, slot in v, w, slot in w) per
// transfer, with graph_done on a graph's last edge and faulty on bad input;
// cfg writes vertex_count (index 0) and vertex_degree (index 1); the user must
// write them only while the block is idle, and the block itself does not enforce it.
// One item is in work at a time. A code byte goes S_START, S_CHKV (again per
// full vertex skipped), S_CHKW, S_WRW, S_PUT; a self loop or a fault goes to
// S_PUT early. A bad header or a stream end inside a record goes from S_IDLE
// to S_PUT, and the next byte is taken once the result is in the output
// register. A header replays each stored byte via S_RPL and S_RPLD through
// the same path. The cost is set by the read-modify-write of the per-vertex
// degree memory and the code store read during replay.
// The result sits in an output register: the next byte is taken while it
// waits, but a new result stalls until edges takes the previous one.
// Reset (synchronous, rst high) sets n=32, k=3, closes any record and marks
// all degrees zero through per-vertex valid bits; the code store holds
// nothing until written, and replaying unwritten entries is undefined.
module regular_graph_shortcode_decoder #(
  parameter int MAX_VERTICES = 32,
  parameter int MAX_DEGREE   = 8,
  parameter int MAX_EDGES    = 64
) (
  input logic         clk,
  input logic         rst,
  rgsd_code_if.sink   codes,
  rgsd_edge_if.source edges,
  rgsd_cfg_if.sink    cfg
);
  import rgsd_pkg::*;

  localparam int VW  = $clog2(MAX_VERTICES + 1);
  localparam int VCW = $clog2(MAX_VERTICES + 2);
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int PW  = $clog2(MAX_EDGES + 1);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RPL, S_RPLD, S_START, S_CHKV, S_CHKW, S_WRW, S_PUT
  } state_t;

  state_t            state, state_next;
  logic [CNT_W-1:0]  vtx_cnt;
  logic [DEG_W-1:0]  vtx_deg;
  logic [VTX_W-1:0]  cur, cur_next;
  logic [PW-1:0]     pos, pos_next;
  logic              in_record, in_record_next;
  logic [PW-1:0]     ridx, ridx_next;
  logic [PW-1:0]     slen, slen_next;
  logic              rep, rep_next;
  logic [BYTE_W-1:0] w, w_next;
  logic              last, last_next;
  logic [VCW-1:0]    vcur, vcur_next;
  logic [SLOT_W-1:0] fv, fv_next;
  logic [SLOT_W-1:0] fw, fw_next;
  rgsd_result_t      res, res_next;
  rgsd_result_t      o_res;
  logic              o_vld, o_vld_next, out_load;

  logic [VCW-1:0]    n_eff;
  logic [DEG_W-1:0]  k_eff;
  logic [9:0]        nk;
  logic [PW-1:0]     code_len;

  logic [SLOT_W-1:0] fill_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] fill_vld;
  logic              fill_re, fill_we, fill_clr, fill_rvld;
  logic [AW-1:0]     fill_raddr, fill_waddr;
  logic [SLOT_W-1:0] fill_wdata, fill_rd, fill_cur;

  logic [VW-1:0]     code_mem [MAX_EDGES];
  logic              code_we, code_re;
  logic [EAW-1:0]    code_waddr, code_raddr;
  logic [VW-1:0]     code_wdata, code_rd;

  logic              b_ok;
  logic [VCW-1:0]    vstart, vinc;

  always_comb begin
    n_eff = ({1'b0, vtx_cnt} > 7'(MAX_VERTICES)) ? VCW'(MAX_VERTICES) : VCW'(vtx_cnt);
    k_eff = (vtx_deg > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : vtx_deg;
    nk    = 10'(n_eff) * 10'(k_eff);
    code_len = ((nk >> 1) > 10'(MAX_EDGES)) ? PW'(MAX_EDGES) : PW'(nk >> 1);
  end

  assign codes.ready = (state == S_IDLE);
  assign cfg.ready   = 1'b1;
  assign out_load    = (state == S_PUT) && (!o_vld || edges.ready);
  assign o_vld_next  = out_load || (o_vld && !edges.ready);
  assign fill_cur    = fill_rvld ? fill_rd : '0;
  assign b_ok        = (codes.code_byte != '0) && (9'(codes.code_byte) <= 9'(n_eff));
  assign vstart      = (cur == '0) ? VCW'(1) : VCW'(cur);
  assign vinc        = vcur + VCW'(1);

  always_comb begin
    state_next     = state;
    cur_next       = cur;
    pos_next       = pos;
    in_record_next = in_record;
    ridx_next      = ridx;
    slen_next      = slen;
    rep_next       = rep;
    w_next         = w;
    last_next      = last;
    vcur_next      = vcur;
    fv_next        = fv;
    fw_next        = fw;
    res_next       = res;
    fill_re        = 1'b0;
    fill_raddr     = '0;
    fill_we        = 1'b0;
    fill_waddr     = '0;
    fill_wdata     = '0;
    fill_clr       = 1'b0;
    code_we        = 1'b0;
    code_waddr     = '0;
    code_wdata     = '0;
    code_re        = 1'b0;
    code_raddr     = '0;

    case (state)
      S_IDLE: begin
        if (codes.valid) begin
          res_next = '0;
          rep_next = 1'b0;
          if (codes.stream_end) begin
            if (in_record) begin
              in_record_next = 1'b0;
              pos_next = '0;
              res_next.faulty = 1'b1;
              state_next = S_PUT;
            end
          end else if (!in_record) begin
            if (9'(codes.code_byte) > 9'(code_len)) begin
              res_next.faulty = 1'b1;
              state_next = S_PUT;
            end else begin
              fill_clr  = 1'b1;
              cur_next  = VTX_W'(1);
              ridx_next = '0;
              slen_next = PW'(codes.code_byte);
              rep_next  = 1'b1;
              if (9'(codes.code_byte) == 9'(code_len)) begin
                pos_next = '0;
              end else begin
                in_record_next = 1'b1;
                pos_next = PW'(codes.code_byte);
              end
              if (codes.code_byte != '0) begin
                state_next = S_RPL;
              end
            end
          end else if (pos >= code_len) begin
            in_record_next = 1'b0;
            pos_next = '0;
            res_next.faulty = 1'b1;
            res_next.graph_done = 1'b1;
            state_next = S_PUT;
          end else begin
            code_we    = 1'b1;
            code_waddr = EAW'(pos);
            code_wdata = b_ok ? VW'(codes.code_byte) : '0;
            w_next     = codes.code_byte;
            last_next  = (pos + PW'(1)) == code_len;
            if ((pos + PW'(1)) == code_len) begin
              in_record_next = 1'b0;
              pos_next = '0;
            end else begin
              pos_next = pos + PW'(1);
            end
            state_next = S_START;
          end
        end
      end
      S_RPL: begin
        code_re    = 1'b1;
        code_raddr = EAW'(ridx);
        last_next  = (ridx + PW'(1)) == code_len;
        state_next = S_RPLD;
      end
      S_RPLD: begin
        w_next = BYTE_W'(code_rd);
        state_next = S_START;
      end
      S_START: begin
        res_next = '0;
        res_next.graph_done = last;
        vcur_next = vstart;
        if (vstart <= n_eff) begin
          fill_re    = 1'b1;
          fill_raddr = AW'(vstart - VCW'(1));
          state_next = S_CHKV;
        end else begin
          cur_next = VTX_W'(vstart);
          res_next.faulty = 1'b1;
          state_next = S_PUT;
        end
      end
      S_CHKV: begin
        if (fill_cur >= k_eff) begin
          vcur_next = vinc;
          if (vinc <= n_eff) begin
            fill_re    = 1'b1;
            fill_raddr = AW'(vcur);
          end else begin
            cur_next = VTX_W'(vinc);
            res_next.faulty = 1'b1;
            state_next = S_PUT;
          end
        end else begin
          cur_next = VTX_W'(vcur);
          fv_next  = fill_cur;
          if (w == '0 || 9'(w) > 9'(n_eff)) begin
            res_next.faulty = 1'b1;
            state_next = S_PUT;
          end else if (BYTE_W'(vcur) == w) begin
            if (5'(fill_cur) + 5'd2 <= 5'(k_eff)) begin
              fill_we    = 1'b1;
              fill_waddr = AW'(vcur - VCW'(1));
              fill_wdata = fill_cur + SLOT_W'(2);
              res_next.first_vertex  = VTX_W'(vcur);
              res_next.first_slot    = fill_cur + SLOT_W'(1);
              res_next.second_vertex = VTX_W'(w);
              res_next.second_slot   = fill_cur + SLOT_W'(2);
            end else begin
              res_next.faulty = 1'b1;
            end
            state_next = S_PUT;
          end else begin
            fill_re    = 1'b1;
            fill_raddr = AW'(w - BYTE_W'(1));
            state_next = S_CHKW;
          end
        end
      end
      S_CHKW: begin
        if (fill_cur < k_eff) begin
          fill_we    = 1'b1;
          fill_waddr = AW'(vcur - VCW'(1));
          fill_wdata = fv + SLOT_W'(1);
          fw_next    = fill_cur;
          state_next = S_WRW;
        end else begin
          res_next.faulty = 1'b1;
          state_next = S_PUT;
        end
      end
      S_WRW: begin
        fill_we    = 1'b1;
        fill_waddr = AW'(w - BYTE_W'(1));
        fill_wdata = fw + SLOT_W'(1);
        res_next.first_vertex  = VTX_W'(vcur);
        res_next.first_slot    = fv + SLOT_W'(1);
        res_next.second_vertex = VTX_W'(w);
        res_next.second_slot   = fw + SLOT_W'(1);
        state_next = S_PUT;
      end
      S_PUT: begin
        if (out_load) begin
          if (rep && ((ridx + PW'(1)) < slen)) begin
            ridx_next  = ridx + PW'(1);
            state_next = S_RPL;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      vtx_cnt   <= CNT_W'(32);
      vtx_deg   <= DEG_W'(3);
      cur       <= VTX_W'(1);
      pos       <= '0;
      in_record <= 1'b0;
      rep       <= 1'b0;
      o_vld     <= 1'b0;
      fill_vld  <= '0;
    end else begin
      state     <= state_next;
      cur       <= cur_next;
      pos       <= pos_next;
      in_record <= in_record_next;
      rep       <= rep_next;
      o_vld     <= o_vld_next;
      if (fill_clr) begin
        fill_vld <= '0;
      end else if (fill_we) begin
        fill_vld[fill_waddr] <= 1'b1;
      end
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          CFG_VERTEX_COUNT:  vtx_cnt <= CNT_W'(cfg.data);
          CFG_VERTEX_DEGREE: vtx_deg <= DEG_W'(cfg.data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    ridx <= ridx_next;
    slen <= slen_next;
    w    <= w_next;
    last <= last_next;
    vcur <= vcur_next;
    fv   <= fv_next;
    fw   <= fw_next;
    res  <= res_next;
    if (out_load) begin
      o_res <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (fill_we) begin
      fill_mem[fill_waddr] <= fill_wdata;
    end
    if (fill_re) begin
      fill_rd   <= fill_mem[fill_raddr];
      fill_rvld <= fill_vld[fill_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    if (code_re) begin
      code_rd <= code_mem[code_raddr];
    end
  end

  assign edges.valid         = o_vld;
  assign edges.first_vertex  = o_res.first_vertex;
  assign edges.first_slot    = o_res.first_slot;
  assign edges.second_vertex = o_res.second_vertex;
  assign edges.second_slot   = o_res.second_slot;
  assign edges.graph_done    = o_res.graph_done;
  assign edges.faulty        = o_res.faulty;

  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    edges.valid && edges.faulty |->
      edges.first_vertex == '0 && edges.first_slot == '0 &&
      edges.second_vertex == '0 && edges.second_slot == '0)
    else $error("faulty edge carries nonzero fields");

  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    edges.valid && !edges.faulty |->
      edges.first_slot != '0 && edges.second_slot != '0 &&
      edges.first_slot <= k_eff && edges.second_slot <= k_eff)
    else $error("edge slot out of degree range");

  a_vertex_range: assert property (@(posedge clk) disable iff (rst)
    state == S_CHKV |-> vcur != '0 && vcur <= n_eff)
    else $error("degree check on vertex outside the graph");

endmodule
